// ===== rtl/core/riff_chunk_resync_scanner_core_defines.svh =====
// assertion macros for the checker file rcrs_checker.sv
`ifndef RIFF_CHUNK_RESYNC_SCANNER_CORE_DEFINES_SVH
`define RIFF_CHUNK_RESYNC_SCANNER_CORE_DEFINES_SVH

// property checked only while out of reset
`define RCRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define RCRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/rcrs_pkg.sv =====
package rcrs_pkg;

    localparam int unsigned WINDOW_BYTES = 8;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned STREAM_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE    = 1'd1;

    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_UPPER_J = 8'h4A;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_UPPER_N = 8'h4E;
    localparam logic [7:0] CH_UPPER_K = 8'h4B;

    // entry 0 is the oldest byte, entry WINDOW_BYTES-1 the newest
    typedef logic [WINDOW_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        logic                overrun;
        logic                skip_hdr;
        logic                hit;
        logic [STREAM_W-1:0] stream;
        logic [31:0]         size;
    } t_decision;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // two decimal digits to 0..99, x10 done as shifts
    function automatic logic [STREAM_W-1:0] two_digits(input logic [7:0] a,
                                                       input logic [7:0] b);
        logic [3:0]          tens;
        logic [3:0]          ones;
        logic [STREAM_W-1:0] t7;
        tens = 4'(a - CH_ZERO);
        ones = 4'(b - CH_ZERO);
        t7   = {3'b000, tens};
        return (t7 << 3) + (t7 << 1) + {3'b000, ones};
    endfunction

    function automatic t_window full_fill();
        t_window w;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            w[i] = FILL_BYTE;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/rcrs_match.sv =====
module rcrs_match (
    input  rcrs_pkg::t_window                  i_window,
    input  logic [31:0]                        i_byte_offset,
    input  logic [rcrs_pkg::STREAM_W-1:0]      i_stream_count,
    input  logic [31:0]                        i_file_size,
    output rcrs_pkg::t_decision                o_decision
);

    logic [31:0]                   size;
    logic [32:0]                   end_sum;
    logic                          overrun;
    logic                          d23;
    logic                          d01;
    logic [rcrs_pkg::STREAM_W-1:0] sidx23;
    logic [rcrs_pkg::STREAM_W-1:0] sidx01;
    logic                          ix_hit;
    logic                          junk_hit;
    logic                          idx1_hit;
    logic                          sel_valid;
    logic [rcrs_pkg::STREAM_W-1:0] sel_idx;

    assign size    = {i_window[7], i_window[6], i_window[5], i_window[4]};
    assign end_sum = {1'b0, i_byte_offset} + {1'b0, size};
    assign overrun = (end_sum > {1'b0, i_file_size}) || i_window[0][7];

    assign d23    = rcrs_pkg::is_dec(i_window[2]) && rcrs_pkg::is_dec(i_window[3]);
    assign d01    = rcrs_pkg::is_dec(i_window[0]) && rcrs_pkg::is_dec(i_window[1]);
    assign sidx23 = rcrs_pkg::two_digits(i_window[2], i_window[3]);
    assign sidx01 = rcrs_pkg::two_digits(i_window[0], i_window[1]);

    assign ix_hit   = (i_window[0] == rcrs_pkg::CH_LOWER_I)
                   && (i_window[1] == rcrs_pkg::CH_LOWER_X)
                   && d23 && (sidx23 < i_stream_count);
    assign junk_hit = (i_window[0] == rcrs_pkg::CH_UPPER_J)
                   && (i_window[1] == rcrs_pkg::CH_UPPER_U)
                   && (i_window[2] == rcrs_pkg::CH_UPPER_N)
                   && (i_window[3] == rcrs_pkg::CH_UPPER_K);
    assign idx1_hit = (i_window[0] == rcrs_pkg::CH_LOWER_I)
                   && (i_window[1] == rcrs_pkg::CH_LOWER_D)
                   && (i_window[2] == rcrs_pkg::CH_LOWER_X)
                   && (i_window[3] == rcrs_pkg::CH_ONE);

    // leading digits win, else fall back to the third and fourth bytes
    assign sel_valid = d01 || d23;
    assign sel_idx   = d01 ? sidx01 : sidx23;

    always_comb begin
        o_decision.overrun  = overrun;
        o_decision.skip_hdr = !overrun && (ix_hit || junk_hit || idx1_hit);
        o_decision.hit      = !overrun && !(ix_hit || junk_hit || idx1_hit)
                           && sel_valid && (sel_idx < i_stream_count);
        o_decision.stream   = sel_idx;
        o_decision.size     = size;
    end

endmodule

// ===== rtl/core/riff_chunk_resync_scanner_core.sv =====
// channel | valid      | stall       | payload
// input   | i_in_valid | o_in_stall  | i_data_byte, i_byte_offset, i_restart
// output  | o_out_valid| i_out_stall | o_found_stream, o_payload_size, o_header_offset
//
// one byte per cycle when not stalled; found chunks show from the output register
// the window and skip counter update in the cycle the byte leaves the input register
// i_rst_n is synchronous: window refills with 0xFF, skip counter and valids clear
// a stalled result holds the input register; o_in_stall rises only then
module riff_chunk_resync_scanner_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic [31:0]                       i_byte_offset,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rcrs_pkg::STREAM_W-1:0]     o_found_stream,
    output logic [31:0]                       o_payload_size,
    output logic [31:0]                       o_header_offset
);

    logic [rcrs_pkg::STREAM_W-1:0] r_stream_count;
    logic [31:0]                   r_file_size;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic [31:0] r_s1_offset;
    logic        r_s1_restart;

    rcrs_pkg::t_window r_window;
    rcrs_pkg::t_window n_window;
    rcrs_pkg::t_window base_window;
    rcrs_pkg::t_window shifted;
    logic [31:0]       r_skip_left;
    logic [31:0]       n_skip_left;

    logic                          r_out_valid;
    logic [rcrs_pkg::STREAM_W-1:0] r_out_stream;
    logic [31:0]                   r_out_size;
    logic [31:0]                   r_out_hdr_off;

    rcrs_pkg::t_decision decision;
    logic                s1_adv;
    logic                s1_fire;
    logic                dropping;
    logic                emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_count <= '0;
            r_file_size    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rcrs_pkg::CFG_STREAM_COUNT: begin
                    r_stream_count <= i_cfg_data[rcrs_pkg::STREAM_W-1:0];
                end
                rcrs_pkg::CFG_FILE_SIZE: begin
                    r_file_size <= i_cfg_data[31:0];
                end
            endcase
        end
    end

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_byte    <= i_data_byte;
            r_s1_offset  <= i_byte_offset;
            r_s1_restart <= i_restart;
        end
    end

    // restart wipes state before the byte itself is taken
    assign base_window = r_s1_restart ? rcrs_pkg::full_fill() : r_window;
    assign dropping    = !r_s1_restart && (r_skip_left != '0);
    assign shifted     = {r_s1_byte, base_window[rcrs_pkg::WINDOW_BYTES-1:1]};

    rcrs_match u_match (
        .i_window       (shifted),
        .i_byte_offset  (r_s1_offset),
        .i_stream_count (r_stream_count),
        .i_file_size    (r_file_size),
        .o_decision     (decision)
    );

    assign emit = !dropping && decision.hit;

    always_comb begin
        n_window    = r_window;
        n_skip_left = r_skip_left;
        if (dropping) begin
            n_skip_left = r_skip_left - 32'd1;
        end else if (decision.skip_hdr) begin
            n_skip_left = decision.size;
            n_window    = rcrs_pkg::full_fill();
        end else if (decision.hit) begin
            n_skip_left = '0;
            n_window    = rcrs_pkg::full_fill();
        end else begin
            n_skip_left = '0;
            n_window    = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= rcrs_pkg::full_fill();
            r_skip_left <= '0;
        end else if (s1_fire) begin
            r_window    <= n_window;
            r_skip_left <= n_skip_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= s1_fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out_stream  <= decision.stream;
            r_out_size    <= decision.size;
            r_out_hdr_off <= r_s1_offset - 32'd7;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found_stream  = r_out_stream;
    assign o_payload_size  = r_out_size;
    assign o_header_offset = r_out_hdr_off;

endmodule

// ===== rtl/core/rcrs_checker.sv =====
`include "riff_chunk_resync_scanner_core_defines.svh"

module rcrs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [rcrs_pkg::STREAM_W-1:0]     o_found_stream,
    input logic [31:0]                       o_payload_size,
    input logic [31:0]                       o_header_offset
);

    // a reset edge leaves no result pending
    `RCRS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // input backs up only behind a held result
    `RCRS_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled with output free")

    // stream numbers come from two decimal digits
    `RCRS_ASSERT(a_stream_range, i_clk, i_rst_n, o_out_valid |-> (o_found_stream < 7'd100), "stream number out of range")

    // a held result beat keeps its payload
    `RCRS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_payload_size) && $stable(o_header_offset) && $stable(o_found_stream)), "stalled result changed")

endmodule

bind riff_chunk_resync_scanner_core rcrs_checker u_rcrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_found_stream  (o_found_stream),
    .o_payload_size  (o_payload_size),
    .o_header_offset (o_header_offset)
);

// ===== sim/riff_chunk_resync_scanner_core_tb.sv =====
module riff_chunk_resync_scanner_core_tb;
    import rcrs_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_BYTES = 150;
    localparam int PHASES      = 9;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] offset;
        logic        restart;
    } file_beat_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [31:0]         size;
        logic [31:0]         hdr_off;
    } chunk_hit_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte;
    logic [31:0]           i_byte_offset;
    logic                  i_restart;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STREAM_W-1:0]   o_found_stream;
    logic [31:0]           o_payload_size;
    logic [31:0]           o_header_offset;

    riff_chunk_resync_scanner_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_byte_offset   (i_byte_offset),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found_stream  (o_found_stream),
        .o_payload_size  (o_payload_size),
        .o_header_offset (o_header_offset)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    file_beat_t file_bytes[$];
    chunk_hit_t expected_chunks[$];

    // scanner state as the block should hold it
    logic [7:0]          chunk_win [WINDOW_BYTES];
    logic [31:0]         drop_count;
    logic [STREAM_W-1:0] model_streams;
    logic [31:0]         model_file_size;

    int          mismatches;
    int          quiet_cycles;
    int          bytes_made;
    logic [31:0] next_offset;
    bit          in_busy;
    int          in_wait;
    bit          in_calm;
    int          out_hold;
    bit          out_calm;
    logic        beat_in_taken;
    logic        beat_out_taken;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // stream number of two id bytes, 1000 when they are not both digits
    function automatic int stream_of(logic [7:0] a, logic [7:0] b);
        if (!(is_digit(a) && is_digit(b)))
            return 1000;
        return int'(a - CH_ZERO) * 10 + int'(b - CH_ZERO);
    endfunction

    function automatic void refill_window();
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            chunk_win[i] = FILL_BYTE;
        end
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic [31:0] off, logic rs);
        logic [31:0] size;
        int          sno;
        bit          drop;
        if (rs) begin
            refill_window();
            drop_count = '0;
        end else if (drop_count != 0) begin
            drop_count = drop_count - 1;
            return;
        end
        for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
            chunk_win[i] = chunk_win[i+1];
        end
        chunk_win[WINDOW_BYTES-1] = b;
        size = {chunk_win[7], chunk_win[6], chunk_win[5], chunk_win[4]};
        sno  = stream_of(chunk_win[2], chunk_win[3]);
        // size check is done one bit wider, no wrap
        if (({1'b0, off} + {1'b0, size}) > {1'b0, model_file_size} || chunk_win[0] > 8'd127)
            return;
        drop = (chunk_win[0] == CH_LOWER_I && chunk_win[1] == CH_LOWER_X &&
                sno < int'(model_streams)) ||
               (chunk_win[0] == CH_UPPER_J && chunk_win[1] == CH_UPPER_U &&
                chunk_win[2] == CH_UPPER_N && chunk_win[3] == CH_UPPER_K) ||
               (chunk_win[0] == CH_LOWER_I && chunk_win[1] == CH_LOWER_D &&
                chunk_win[2] == CH_LOWER_X && chunk_win[3] == CH_ONE);
        if (drop) begin
            drop_count = size;
            refill_window();
            return;
        end
        if (is_digit(chunk_win[0]) && is_digit(chunk_win[1]))
            sno = stream_of(chunk_win[0], chunk_win[1]);
        if (sno < int'(model_streams)) begin
            expected_chunks.push_back('{STREAM_W'(sno), size, off - 32'd7});
            refill_window();
        end
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0: return CH_ZERO + 8'($urandom_range(0, 9));
            1: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 16'hFFFF);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic int pick_stream();
        if (model_streams == 0 || $urandom_range(0, 3) == 0)
            return $urandom_range(0, 99);
        return $urandom_range(0, int'(model_streams) - 1);
    endfunction

    task automatic add_byte(logic [7:0] b, bit rs);
        file_bytes.push_back('{b, next_offset, rs});
        next_offset = next_offset + 1;
        bytes_made++;
    endtask

    task automatic add_header(logic [31:0] id, logic [31:0] size, bit rs);
        add_byte(id[31:24], rs);
        add_byte(id[23:16], 1'b0);
        add_byte(id[15:8], 1'b0);
        add_byte(id[7:0], 1'b0);
        for (int i = 0; i < 4; i++) begin
            add_byte(size[8*i +: 8], 1'b0);
        end
    endtask

    function automatic logic [15:0] digit_pair(int n);
        return {CH_ZERO + 8'(n / 10), CH_ZERO + 8'(n % 10)};
    endfunction

    // one header, its payload, or some filler
    task automatic add_sequence();
        bit          rs;
        logic [31:0] size;
        logic [31:0] id;
        int          n;
        rs   = ($urandom_range(0, 11) == 0);
        size = pick_size();
        case ($urandom_range(0, 9))
            0, 1, 9: begin
                add_header({digit_pair(pick_stream()), pick_char(), pick_char()}, size, rs);
                n = $urandom_range(0, 10);
                repeat (n) add_byte(pick_char(), 1'b0);
            end
            2: add_header({pick_char(), pick_char(), digit_pair(pick_stream())}, size, rs);
            3, 4, 5: begin
                if ($urandom_range(0, 9) != 0)
                    size = $urandom_range(0, 24);
                case ($urandom_range(0, 2))
                    0: id = {CH_LOWER_I, CH_LOWER_X, digit_pair(pick_stream())};
                    1: id = {CH_UPPER_J, CH_UPPER_U, CH_UPPER_N, CH_UPPER_K};
                    default: id = {CH_LOWER_I, CH_LOWER_D, CH_LOWER_X, CH_ONE};
                endcase
                add_header(id, size, rs);
                n = (size > 40) ? 40 : int'(size);
                // dropped payload, now and then cut short by a restart
                repeat (n) add_byte(pick_char(), $urandom_range(0, 29) == 0);
            end
            6: begin
                n = $urandom_range(1, 12);
                repeat (n) add_byte(pick_char(), rs);
            end
            7: begin
                id = {digit_pair(pick_stream()), pick_char(), pick_char()};
                n  = $urandom_range(1, 7);
                for (int i = 0; i < n; i++) begin
                    add_byte(i < 4 ? id[31-8*i -: 8] : size[8*(i-4) +: 8], rs && i == 0);
                end
            end
            default: begin
                // near misses of the skip ids
                id = {CH_UPPER_J, CH_UPPER_U, CH_UPPER_N, CH_UPPER_K};
                case ($urandom_range(0, 2))
                    0: id[8*$urandom_range(0, 3) +: 8] = pick_char();
                    1: id = {CH_LOWER_I, CH_LOWER_X, pick_char(), pick_char()};
                    default: id = {CH_LOWER_I, CH_LOWER_D, CH_LOWER_X, pick_char()};
                endcase
                add_header(id, $urandom_range(0, 24), rs);
            end
        endcase
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STREAM_COUNT: model_streams   = val[STREAM_W-1:0];
            CFG_FILE_SIZE:    model_file_size = val;
            default: ;
        endcase
    endtask

    task automatic settle_idle();
        while (file_bytes.size() != 0 || in_busy || expected_chunks.size() != 0)
            @(posedge i_clk);
        // bytes that find nothing may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    // input side
    always @(negedge i_clk) begin
        file_beat_t cur;
        if (in_busy && beat_in_taken) begin
            in_busy = 1'b0;
            in_wait = draw_wait(in_calm);
        end
        if (!in_busy) begin
            if (in_wait > 0) begin
                in_wait--;
            end else if (file_bytes.size() != 0) begin
                cur = file_bytes.pop_front();
                i_data_byte   <= cur.data;
                i_byte_offset <= cur.offset;
                i_restart     <= cur.restart;
                in_busy = 1'b1;
            end
        end
        i_in_valid <= in_busy;
    end

    // output side
    always @(negedge i_clk) begin
        if (beat_out_taken)
            out_hold = draw_wait(out_calm);
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        chunk_hit_t got;
        chunk_hit_t want;
        beat_in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        beat_out_taken <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_found_stream, o_payload_size, o_header_offset};
                if (expected_chunks.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected chunk stream %0d size %0h offset %0h",
                             $time, got.stream, got.size, got.hdr_off);
                end else begin
                    want = expected_chunks.pop_front();
                    if (got.stream != want.stream || got.size != want.size ||
                        got.hdr_off != want.hdr_off) begin
                        mismatches++;
                        $display("%0t: expected stream %0d size %0h offset %0h, got %0d %0h %0h",
                                 $time, want.stream, want.size, want.hdr_off,
                                 got.stream, got.size, got.hdr_off);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                scan_byte(i_data_byte, i_byte_offset, i_restart);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] limit;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_byte_offset = '0;
        i_restart     = 1'b0;
        i_out_stall   = 1'b0;
        beat_in_taken  = 1'b0;
        beat_out_taken = 1'b0;
        in_busy       = 1'b0;
        in_wait       = 0;
        out_hold      = 0;
        in_calm       = 1'b0;
        out_calm      = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        bytes_made    = 0;
        next_offset   = '0;
        refill_window();
        drop_count      = '0;
        model_streams   = '0;
        model_file_size = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: next_offset = $urandom_range(0, 2000);
                1: next_offset = 32'hFFFF_FFFF - $urandom_range(0, 300);
                2: next_offset = $urandom;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: limit = 32'hFFFF_FFFF;
                1: limit = (next_offset > 32'hFFFF_F000) ? 32'hFFFF_FFFF :
                           next_offset + $urandom_range(0, 3000);
                2: limit = $urandom;
                default: limit = $urandom_range(0, 5000);
            endcase
            case (p)
                0, 1: limit = 32'hFFFF_FFFF;
                3:    limit = '0;
                default: ;
            endcase
            write_reg(CFG_STREAM_COUNT, p == 0 ? 100 : p == 1 ? 0 : p == 2 ? 1 :
                                        $urandom_range(0, 100));
            write_reg(CFG_FILE_SIZE, limit);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);

            if (p == 0) begin
                // restart on a leading-digit id, widest stream number, offset zero
                next_offset = '0;
                add_header({digit_pair(99), CH_LOWER_X, CH_LOWER_D}, 32'd3, 1'b1);
                // padding chunk with one byte to drop
                add_header({CH_UPPER_J, CH_UPPER_U, CH_UPPER_N, CH_UPPER_K}, 32'd1, 1'b0);
                add_byte(8'h00, 1'b0);
                // digits in the second pair only, ending at the top offset
                next_offset = 32'hFFFF_FFF8;
                add_header({CH_LOWER_D, CH_LOWER_X, digit_pair(7)}, 32'd0, 1'b0);
            end
            bytes_made = 0;
            while (bytes_made < PHASE_BYTES)
                add_sequence();
            settle_idle();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rcrs_pkg.sv
rtl/core/rcrs_match.sv
rtl/core/riff_chunk_resync_scanner_core.sv
rtl/core/rcrs_checker.sv
sim/riff_chunk_resync_scanner_core_tb.sv
